### rtl/core/sat_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sat_pkg - shared definitions for the summed-area table query block
// Sizes, field widths, opcodes, status codes, register indexes and the
// configuration bundle passed from the register file to the core.
// ---------------------------------------------------------------------------
package sat_pkg;

  // matrix size limits and arithmetic widths
  localparam int MAX_ROWS      = 64;
  localparam int MAX_COLS      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int SUM_WIDTH     = 38;
  localparam int TAB_WIDTH     = 44;

  // coordinate and table address widths
  localparam int DIM_W     = 7;
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int COL_IDX_W = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_IDX_W + COL_IDX_W;

  // stream and register port widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;
  localparam int STATUS_W    = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // opcodes carried in the input tuser bit
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // query status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COORD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd2;

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [TAB_WIDTH-1:0] tab_t;
  typedef logic [SUM_WIDTH-1:0] sum_t;

  // configuration seen by the core
  typedef struct packed {
    logic restart;
    dim_t rows;
    dim_t cols;
  } cfg_t;

  // zero acts as one, values above the limit act as the limit
  function automatic dim_t clamp_dim(input dim_t v, input dim_t maxv);
    dim_t res;
    res = v;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

endpackage

### rtl/core/sat_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sat_ram - table memory
// One write port and two read ports sharing one read enable; read data is
// registered and holds its value while the read enable is low.
// ---------------------------------------------------------------------------
module sat_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 44
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/core/sat_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sat_cfg - register file
// Holds the clamped matrix dimensions, serves reads and flags a restart of
// the loader on every write.
// ---------------------------------------------------------------------------
module sat_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sat_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sat_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sat_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output sat_pkg::cfg_t                    cfg
);

  sat_pkg::dim_t rows_r, rows_nxt;
  sat_pkg::dim_t cols_r, cols_nxt;
  logic          wr_en;
  logic          reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  // write decode with clamping
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (wr_en) begin
      case (reg_idx)
        sat_pkg::REG_ROWS: begin
          rows_nxt = sat_pkg::clamp_dim(cfg_pwdata[sat_pkg::DIM_W-1:0],
                                        sat_pkg::dim_t'(sat_pkg::MAX_ROWS));
        end
        sat_pkg::REG_COLS: begin
          cols_nxt = sat_pkg::clamp_dim(cfg_pwdata[sat_pkg::DIM_W-1:0],
                                        sat_pkg::dim_t'(sat_pkg::MAX_COLS));
        end
        default: begin
          rows_nxt = rows_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= sat_pkg::dim_t'(sat_pkg::MAX_ROWS);
      cols_r <= sat_pkg::dim_t'(sat_pkg::MAX_COLS);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      sat_pkg::REG_ROWS: cfg_prdata = sat_pkg::CFG_DATA_W'(rows_r);
      sat_pkg::REG_COLS: cfg_prdata = sat_pkg::CFG_DATA_W'(cols_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg.restart = wr_en;
  assign cfg.rows    = rows_r;
  assign cfg.cols    = cols_r;

endmodule

### rtl/core/summed_area_table_query.sv
`timescale 1ns / 1ps
// Timing: a load reads the table entry above, then writes the new entry.
// A query does two rounds of paired reads on the dual-read table memory,
// then the final add into the result register; it waits there while
// the result register is full. One item in work: none is taken until the last is done.
// Reset (rst_n, synchronous, active low) clears the loader, the loaded flag,
// the output valid flag and sets both dimensions to 64; the table is not cleared.
// ---------------------------------------------------------------------------
// summed_area_table_query - 2D prefix-sum table with rectangle queries
// Load beats build the summed-area table in raster order, query beats return
// inclusive rectangle sums from four table reads.
// ---------------------------------------------------------------------------
module summed_area_table_query (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: element[31:0], row_low[38:32], col_low[45:39],
  //           row_high[52:46], col_high[59:53], zero[63:60]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sat_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,   // opcode[0]
  // out_tdata: rect_sum[43:0], zero[47:44]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sat_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [sat_pkg::STATUS_W-1:0]        out_tuser,  // status[1:0]
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sat_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [sat_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [sat_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_Q1   = 2'd2;
  localparam logic [1:0] S_Q2   = 2'd3;

  localparam int RI = sat_pkg::ROW_IDX_W;
  localparam int CI = sat_pkg::COL_IDX_W;

  sat_pkg::cfg_t cfg;

  logic [1:0]    state_r, state_nxt;
  logic          accept;
  logic          is_load;
  logic          is_query;

  // input fields
  logic [sat_pkg::ELEMENT_WIDTH-1:0] element;
  sat_pkg::dim_t row_low, col_low, row_high, col_high;

  // loader state
  sat_pkg::dim_t load_row_r, load_row_nxt;
  sat_pkg::dim_t load_col_r, load_col_nxt;
  sat_pkg::sum_t rsum_r, rsum_nxt;
  logic          loaded_r, loaded_nxt;
  sat_pkg::sum_t rs_new;
  logic          last_col;
  logic          last_row;
  sat_pkg::dim_t ld_row_m1, ld_row_m2, ld_col_m1;

  // load write-back stage
  sat_pkg::sum_t               lsum_r;
  logic [sat_pkg::ADDR_W-1:0]  waddr_r;
  logic                        above_zero_r;

  // query stage
  sat_pkg::dim_t               rh_m1, rl_m2, ch_m1, cl_m2;
  logic [RI-1:0]               rh_idx_r, rl_idx_r;
  logic [CI-1:0]               cl_idx_r;
  logic                        zr_r, zc_r;
  logic [sat_pkg::STATUS_W-1:0] qstat, qstat_r;
  sat_pkg::tab_t               part_r;

  // memory ports
  logic                        ram_we, ram_re;
  logic [sat_pkg::ADDR_W-1:0]  ram_raddr_a, ram_raddr_b;
  sat_pkg::tab_t               ram_wdata, ram_rdata_a, ram_rdata_b;
  sat_pkg::tab_t               rd_c, rd_d, qsum;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  sat_pkg::tab_t               out_sum_r;
  logic [sat_pkg::STATUS_W-1:0] out_stat_r;
  logic                        out_load;

  sat_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // field unpacking
  assign element  = in_tdata[31:0];
  assign row_low  = in_tdata[38:32];
  assign col_low  = in_tdata[45:39];
  assign row_high = in_tdata[52:46];
  assign col_high = in_tdata[59:53];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign is_load   = accept & (in_tuser == sat_pkg::OP_LOAD);
  assign is_query  = accept & (in_tuser == sat_pkg::OP_QUERY);

  // loader position and running row sum
  assign rs_new   = rsum_r + {{(sat_pkg::SUM_WIDTH-sat_pkg::ELEMENT_WIDTH)
                               {element[sat_pkg::ELEMENT_WIDTH-1]}}, element};
  assign last_col = (load_col_r >= cfg.cols);
  assign last_row = (load_row_r >= cfg.rows);
  assign ld_row_m1 = load_row_r - sat_pkg::dim_t'(1);
  assign ld_row_m2 = load_row_r - sat_pkg::dim_t'(2);
  assign ld_col_m1 = load_col_r - sat_pkg::dim_t'(1);

  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    rsum_nxt     = rsum_r;
    loaded_nxt   = loaded_r;
    if (cfg.restart) begin
      load_row_nxt = sat_pkg::dim_t'(1);
      load_col_nxt = sat_pkg::dim_t'(1);
      rsum_nxt     = '0;
      loaded_nxt   = 1'b0;
    end else if (is_load) begin
      loaded_nxt = 1'b0;
      if (last_col) begin
        load_col_nxt = sat_pkg::dim_t'(1);
        rsum_nxt     = '0;
        if (last_row) begin
          load_row_nxt = sat_pkg::dim_t'(1);
          loaded_nxt   = 1'b1;
        end else begin
          load_row_nxt = load_row_r + sat_pkg::dim_t'(1);
        end
      end else begin
        load_col_nxt = load_col_r + sat_pkg::dim_t'(1);
        rsum_nxt     = rs_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= sat_pkg::dim_t'(1);
      load_col_r <= sat_pkg::dim_t'(1);
      rsum_r     <= '0;
      loaded_r   <= 1'b0;
    end else begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      rsum_r     <= rsum_nxt;
      loaded_r   <= loaded_nxt;
    end
  end

  // query coordinate check
  always_comb begin
    if (!loaded_r) begin
      qstat = sat_pkg::ST_NOT_LOADED;
    end else if (row_low == '0 || col_low == '0 || row_low > row_high ||
                 col_low > col_high || row_high > cfg.rows ||
                 col_high > cfg.cols) begin
      qstat = sat_pkg::ST_BAD_COORD;
    end else begin
      qstat = sat_pkg::ST_OK;
    end
  end

  assign rh_m1 = row_high - sat_pkg::dim_t'(1);
  assign rl_m2 = row_low - sat_pkg::dim_t'(2);
  assign ch_m1 = col_high - sat_pkg::dim_t'(1);
  assign cl_m2 = col_low - sat_pkg::dim_t'(2);

  // payload registers for both item kinds
  always_ff @(posedge clk) begin
    if (is_load) begin
      lsum_r       <= rs_new;
      waddr_r      <= {ld_row_m1[RI-1:0], ld_col_m1[CI-1:0]};
      above_zero_r <= (load_row_r == sat_pkg::dim_t'(1));
    end
    if (is_query) begin
      rh_idx_r <= rh_m1[RI-1:0];
      rl_idx_r <= rl_m2[RI-1:0];
      cl_idx_r <= cl_m2[CI-1:0];
      zr_r     <= (row_low == sat_pkg::dim_t'(1));
      zc_r     <= (col_low == sat_pkg::dim_t'(1));
      qstat_r  <= qstat;
    end
    if (state_r == S_Q1) begin
      part_r <= ram_rdata_a - (zr_r ? '0 : ram_rdata_b);
    end
  end

  // memory address selection
  always_comb begin
    ram_re      = 1'b0;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    if (is_load) begin
      ram_re      = 1'b1;
      ram_raddr_a = {ld_row_m2[RI-1:0], ld_col_m1[CI-1:0]};
      ram_raddr_b = {ld_row_m2[RI-1:0], ld_col_m1[CI-1:0]};
    end else if (is_query) begin
      // corners at column col_high
      ram_re      = 1'b1;
      ram_raddr_a = {rh_m1[RI-1:0], ch_m1[CI-1:0]};
      ram_raddr_b = {rl_m2[RI-1:0], ch_m1[CI-1:0]};
    end else if (state_r == S_Q1) begin
      // corners at column col_low - 1
      ram_re      = 1'b1;
      ram_raddr_a = {rh_idx_r, cl_idx_r};
      ram_raddr_b = {rl_idx_r, cl_idx_r};
    end
  end

  // prefix write-back: entry above plus running row sum
  assign ram_we    = (state_r == S_LOAD);
  assign ram_wdata = (above_zero_r ? '0 : ram_rdata_a) +
                     {{(sat_pkg::TAB_WIDTH-sat_pkg::SUM_WIDTH)
                       {lsum_r[sat_pkg::SUM_WIDTH-1]}}, lsum_r};

  sat_ram #(
    .ADDR_W (sat_pkg::ADDR_W),
    .DATA_W (sat_pkg::TAB_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr_r),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // final rectangle sum
  assign rd_c = zc_r ? '0 : ram_rdata_a;
  assign rd_d = (zr_r | zc_r) ? '0 : ram_rdata_b;
  assign qsum = (qstat_r == sat_pkg::ST_OK) ? (part_r - rd_c + rd_d) : '0;

  assign out_load = (state_r == S_Q2) & (~out_valid_r | out_tready);

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (is_load) begin
          state_nxt = S_LOAD;
        end else if (is_query) begin
          state_nxt = S_Q1;
        end
      end
      S_LOAD: state_nxt = S_IDLE;
      S_Q1:   state_nxt = S_Q2;
      S_Q2: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r  <= qsum;
      out_stat_r <= qstat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sat_pkg::OUT_TDATA_W'(out_sum_r);
  assign out_tuser  = out_stat_r;

endmodule
